// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the recent query suppression ring design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks in the same cycle: when the antecedent holds, the consequent must hold too.
`define RQSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqsr assertion failed");
// Checks across a clock edge: when the antecedent holds, the consequent must hold next cycle.
`define RQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqsr assertion failed");
`else
`define RQSR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RQSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rqsr_pkg.sv =====
// Package with the shared types and constants of the recent query suppression ring.
`timescale 1ns / 1ps
package rqsr_pkg;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 8;
    localparam int COUNT_W = 7;

    // Reset value of the hold time register, in seconds.
    localparam int HOLD_RESET = 10;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_ALLOWED = 2'd0,
        VERDICT_IGNORED = 2'd1,
        VERDICT_BANNED  = 2'd2,
        VERDICT_TICK    = 2'd3
    } verdict_t;

    // Flags from the shared comparator.
    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_flags_t;

endpackage

// ===== hdl/rqsr_req_if.sv =====
// Request channel: one word carries a tick or a query.
`timescale 1ns / 1ps
interface rqsr_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [rqsr_pkg::TIME_W-1:0]  now;
    logic [rqsr_pkg::ADDR_W-1:0]  source_address;
    logic                         is_banned;
    logic                         is_broadcast;

    modport source (output valid, command, now, source_address, is_banned, is_broadcast,
                    input ready);
    modport sink (input valid, command, now, source_address, is_banned, is_broadcast,
                  output ready);
endinterface

// ===== hdl/rqsr_rsp_if.sv =====
// Response channel: one word carries the verdict for one request.
`timescale 1ns / 1ps
interface rqsr_rsp_if;
    logic                          valid;
    logic                          ready;
    rqsr_pkg::verdict_t            verdict;
    logic                          overflow;
    logic [rqsr_pkg::COUNT_W-1:0]  expired_count;

    modport source (output valid, verdict, overflow, expired_count, input ready);
    modport sink (input valid, verdict, overflow, expired_count, output ready);
endinterface

// ===== hdl/rqsr_cfg_if.sv =====
// Configuration channel: one word writes the hold time register.
`timescale 1ns / 1ps
interface rqsr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rqsr_pkg::HOLD_W-1:0]  hold_seconds;

    modport source (output valid, hold_seconds, input ready);
    modport sink (input valid, hold_seconds, output ready);
endinterface

// ===== hdl/rqsr_ring.sv =====
// Ring storage: address and expiry memories with one write and one registered read port.
`timescale 1ns / 1ps
module rqsr_ring #(
    parameter int DEPTH = 64,
    parameter int PTR_W = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [PTR_W-1:0]             wr_ptr,
    input  logic [rqsr_pkg::ADDR_W-1:0]  wr_address,
    input  logic [rqsr_pkg::TIME_W-1:0]  wr_expiry,
    input  logic [PTR_W-1:0]             rd_ptr,
    output logic [rqsr_pkg::ADDR_W-1:0]  rd_address,
    output logic [rqsr_pkg::TIME_W-1:0]  rd_expiry
);
    import rqsr_pkg::*;

    logic [ADDR_W-1:0] address_mem [DEPTH];
    logic [TIME_W-1:0] expiry_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            address_mem[wr_ptr] <= wr_address;
            expiry_mem[wr_ptr]  <= wr_expiry;
        end
        rd_address <= address_mem[rd_ptr];
        rd_expiry  <= expiry_mem[rd_ptr];
    end

endmodule

// ===== hdl/rqsr_cmp.sv =====
// Shared comparator used for both the address match and the expiry test.
`timescale 1ns / 1ps
module rqsr_cmp (
    input  logic [rqsr_pkg::TIME_W-1:0]  op_a,
    input  logic [rqsr_pkg::TIME_W-1:0]  op_b,
    output rqsr_pkg::cmp_flags_t         flags
);
    import rqsr_pkg::*;

    always_comb
    begin
        flags.eq = (op_a == op_b);
        flags.ge = (op_a >= op_b);
    end

endmodule

// ===== hdl/recent_query_suppression_ring_unit.sv =====
// Recent query suppression ring: a per-address rate limiter that walks a ring of recently
// admitted IPv4 sources, one entry per clock, through a single memory read port and one
// shared comparator; a request word goes from acceptance through a scan state and a done
// state, and the scan passes over the live entries for a query that misses, the entries
// before the match for a hit and the expired entries for a tick, while a broadcast query
// leaves the scan at once; the response sits in an output register, so a new request may
// be taken while the previous response still waits to be collected.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module recent_query_suppression_ring_unit #(
    parameter int RING_DEPTH       = 64,
    parameter int TICKS_PER_SECOND = 35
) (
    input  logic           clk,
    input  logic           rst_n,
    rqsr_req_if.sink       req,
    rqsr_rsp_if.source     rsp,
    rqsr_cfg_if.sink       cfg
);
    import rqsr_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    // Wide enough for hold_seconds times the tick rate.
    localparam int HT_W  = HOLD_W + $clog2(TICKS_PER_SECOND + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control state.
    state_t             state_reg,     state_next;
    logic [PTR_W-1:0]   head_reg,      head_next;
    logic [PTR_W-1:0]   tail_reg,      tail_next;
    logic [PTR_W-1:0]   cur_reg,       cur_next;
    logic [COUNT_W-1:0] cnt_reg,       cnt_next;
    logic [HT_W-1:0]    hold_ticks_reg, hold_ticks_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Captured request word and the pending result.
    logic               cmd_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               banned_reg;
    logic               bcast_reg;
    verdict_t           res_verdict_reg, res_verdict_next;
    logic               res_overflow_reg, res_overflow_next;

    // Response word register.
    verdict_t           rsp_verdict_reg;
    logic               rsp_overflow_reg;
    logic [COUNT_W-1:0] rsp_count_reg;

    // Ring and comparator connections.
    logic               wr_en;
    logic [TIME_W-1:0]  wr_expiry;
    logic [PTR_W-1:0]   rd_ptr;
    logic [ADDR_W-1:0]  rd_address;
    logic [TIME_W-1:0]  rd_expiry;
    logic [TIME_W-1:0]  cmp_a;
    logic [TIME_W-1:0]  cmp_b;
    cmp_flags_t         flags;
    logic               req_accept;
    logic               load_rsp;

    // Pointers advance modulo the ring depth, which need not be a power of two.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    rqsr_ring #(
        .DEPTH (RING_DEPTH),
        .PTR_W (PTR_W)
    ) u_ring (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_ptr     (tail_reg),
        .wr_address (addr_reg),
        .wr_expiry  (wr_expiry),
        .rd_ptr     (rd_ptr),
        .rd_address (rd_address),
        .rd_expiry  (rd_expiry)
    );

    // A query compares the stored address; a tick tests the current time against the expiry.
    assign cmp_a = (cmd_reg == CMD_QUERY) ? addr_reg : now_reg;
    assign cmp_b = (cmd_reg == CMD_QUERY) ? rd_address : rd_expiry;

    rqsr_cmp u_cmp (
        .op_a  (cmp_a),
        .op_b  (cmp_b),
        .flags (flags)
    );

    assign wr_expiry  = now_reg + TIME_W'(hold_ticks_reg);
    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign cfg.ready  = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.verdict       = rsp_verdict_reg;
    assign rsp.overflow      = rsp_overflow_reg;
    assign rsp.expired_count = rsp_count_reg;

    // The hold time is kept in ticks so that an insertion needs only one add.
    always_comb
    begin
        hold_ticks_next = hold_ticks_reg;
        if (cfg.valid)
        begin
            hold_ticks_next = HT_W'(cfg.hold_seconds) * HT_W'(TICKS_PER_SECOND);
        end
    end

    // Sequencer. The read for the entry at cur_reg is issued in the cycle before, so during the
    // scan the comparator always sees the entry that cur_reg points at.
    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        cur_next          = cur_reg;
        cnt_next          = cnt_reg;
        res_verdict_next  = res_verdict_reg;
        res_overflow_next = res_overflow_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        wr_en             = 1'b0;
        rd_ptr            = cur_reg;
        load_rsp          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_ptr = head_reg;
                if (req_accept)
                begin
                    cur_next   = head_reg;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmd_reg == CMD_TICK)
                begin
                    if ((cur_reg == tail_reg) || !flags.ge)
                    begin
                        res_verdict_next  = VERDICT_TICK;
                        res_overflow_next = 1'b0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        head_next = ring_next(cur_reg);
                        cur_next  = ring_next(cur_reg);
                        rd_ptr    = ring_next(cur_reg);
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                else if (bcast_reg)
                begin
                    res_verdict_next  = VERDICT_ALLOWED;
                    res_overflow_next = 1'b0;
                    state_next        = ST_DONE;
                end
                else if (cur_reg == tail_reg)
                begin
                    res_overflow_next = 1'b0;
                    if (banned_reg)
                    begin
                        res_verdict_next = VERDICT_BANNED;
                    end
                    else
                    begin
                        // Admit the source at the tail; meeting the head empties the ring.
                        wr_en             = 1'b1;
                        tail_next         = ring_next(tail_reg);
                        res_overflow_next = (ring_next(tail_reg) == head_reg);
                        res_verdict_next  = VERDICT_ALLOWED;
                    end
                    state_next = ST_DONE;
                end
                else if (flags.eq)
                begin
                    res_verdict_next  = VERDICT_IGNORED;
                    res_overflow_next = 1'b0;
                    state_next        = ST_DONE;
                end
                else
                begin
                    cur_next = ring_next(cur_reg);
                    rd_ptr   = ring_next(cur_reg);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            hold_ticks_reg <= HT_W'(HOLD_RESET * TICKS_PER_SECOND);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cur_reg        <= cur_next;
            cnt_reg        <= cnt_next;
            hold_ticks_reg <= hold_ticks_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            cmd_reg    <= req.command;
            now_reg    <= req.now;
            addr_reg   <= req.source_address;
            banned_reg <= req.is_banned;
            bcast_reg  <= req.is_broadcast;
        end
        res_verdict_reg  <= res_verdict_next;
        res_overflow_reg <= res_overflow_next;
        if (load_rsp)
        begin
            rsp_verdict_reg  <= res_verdict_reg;
            rsp_overflow_reg <= res_overflow_reg;
            rsp_count_reg    <= (cmd_reg == CMD_TICK) ? cnt_reg : '0;
        end
    end

    // Only a non-broadcast, unbanned query may write the ring.
    `RQSR_ASSERT_SAME(a_write_only_on_admit, clk, rst_n, wr_en,
        (cmd_reg == CMD_QUERY) && !bcast_reg && !banned_reg)
    // A tick response never reports an overflow.
    `RQSR_ASSERT_SAME(a_tick_no_overflow, clk, rst_n,
        rsp.valid && (rsp.verdict == VERDICT_TICK), !rsp.overflow)
    // A query response never reports expired entries.
    `RQSR_ASSERT_SAME(a_query_no_expiry, clk, rst_n,
        rsp.valid && (rsp.verdict != VERDICT_TICK), rsp.expired_count == '0)
    // An accepted word always starts a scan on the next cycle.
    `RQSR_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, req_accept, state_reg == ST_SCAN)
    // During a tick the scan pointer and the head move together.
    `RQSR_ASSERT_SAME(a_tick_cur_is_head, clk, rst_n,
        (state_reg == ST_SCAN) && (cmd_reg == CMD_TICK), cur_reg == head_reg)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the recent query suppression ring unit.
`timescale 1ns / 1ps
module testbench;
    import rqsr_pkg::*;

    localparam int RING_DEPTH       = 64;
    localparam int TICKS_PER_SECOND = 35;
    // The limit leaves ample room for the slowest correct run: each word can cost a full ring
    // walk, a long sender gap and a long receiver stall, plus two long hold-offs.
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int WORDS_PER_PHASE  = 100;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int POOL_SIZE        = 16;

    // A phase either mixes every kind of word, or fills the ring with fresh addresses
    // and no expiry so that the tail runs onto the head.
    typedef enum int {
        MIX_TRAFFIC,
        FILL_RING
    } traffic_t;

    typedef struct {
        logic              command;
        logic [TIME_W-1:0] stamp;
        logic [ADDR_W-1:0] source;
        logic              banned;
        logic              broadcast;
    } request_t;

    typedef struct {
        verdict_t           verdict;
        logic               overflow;
        logic [COUNT_W-1:0] expired;
    } verdict_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rqsr_req_if req_ch ();
    rqsr_rsp_if rsp_ch ();
    rqsr_cfg_if cfg_ch ();

    recent_query_suppression_ring_unit #(
        .RING_DEPTH       (RING_DEPTH),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Request words still to be offered; the front one is the word on the bus.
    request_t      pending[$];
    // Verdicts predicted for accepted words, oldest first.
    verdict_word_t verdicts_due[$];

    // Our own copy of the ring. Only entries between head and tail are ever read, and
    // every one of those has been written by an admitted query first.
    logic [ADDR_W-1:0] ring_addr   [RING_DEPTH];
    logic [TIME_W-1:0] ring_expiry [RING_DEPTH];
    int                ring_head = 0;
    int                ring_tail = 0;
    logic [HOLD_W-1:0] hold_reg  = HOLD_W'(HOLD_RESET);

    // Stimulus state: the running time base and a small set of returning querists.
    logic [TIME_W-1:0] t_base = '0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int   errors       = 0;
    int   words_out    = 0;
    int   cycle_count  = 0;
    int   send_gap     = 0;
    int   rx_stall     = 0;
    int   rx_hold_left = 0;
    int   holds_done   = 0;
    logic tx_eager     = 1'b0;
    logic rx_eager     = 1'b0;

    always #5 clk = ~clk;

    // Works out the verdict of one accepted word and updates the ring copy to match.
    function automatic verdict_word_t judge_word(request_t w);
        verdict_word_t r;
        int            p;
        logic          hit;
        r.verdict  = VERDICT_TICK;
        r.overflow = 1'b0;
        r.expired  = '0;
        hit        = 1'b0;
        if (w.command == CMD_TICK)
        begin
            // Entries leave from the head only; the first live one stops the sweep.
            while (ring_head != ring_tail && w.stamp >= ring_expiry[ring_head])
            begin
                ring_head = (ring_head + 1) % RING_DEPTH;
                r.expired++;
            end
        end
        else if (w.broadcast)
        begin
            // Our own broadcast skips both the suppression scan and the ban list.
            r.verdict = VERDICT_ALLOWED;
        end
        else
        begin
            p = ring_head;
            while (p != ring_tail && !hit)
            begin
                if (ring_addr[p] == w.source)
                    hit = 1'b1;
                p = (p + 1) % RING_DEPTH;
            end
            // A recent match wins over the ban list.
            if (hit)
                r.verdict = VERDICT_IGNORED;
            else if (w.banned)
                r.verdict = VERDICT_BANNED;
            else
            begin
                ring_addr[ring_tail]   = w.source;
                ring_expiry[ring_tail] = w.stamp + TIME_W'(hold_reg) * TIME_W'(TICKS_PER_SECOND);
                ring_tail              = (ring_tail + 1) % RING_DEPTH;
                // When the tail lands on the head the whole ring reads as empty.
                r.overflow             = (ring_tail == ring_head);
                r.verdict              = VERDICT_ALLOWED;
            end
        end
        return r;
    endfunction

    function automatic void queue_word(logic command, logic [TIME_W-1:0] stamp,
                                       logic [ADDR_W-1:0] source, logic banned,
                                       logic broadcast);
        request_t w;
        w.command   = command;
        w.stamp     = stamp;
        w.source    = source;
        w.banned    = banned;
        w.broadcast = broadcast;
        pending.push_back(w);
    endfunction

    // Builds one random word. Most queries come from the returning pool so that the
    // scan finds matches; ticks advance time by up to half a hold period plus four ticks.
    function automatic request_t random_word(traffic_t mode);
        request_t    w;
        int unsigned roll;
        int unsigned span;
        roll        = $urandom_range(0, 99);
        span        = hold_reg * TICKS_PER_SECOND / 2 + 4;
        w.command   = CMD_QUERY;
        w.source    = $urandom();
        w.banned    = 1'b0;
        w.broadcast = 1'b0;
        w.stamp     = t_base;
        if (mode == FILL_RING)
        begin
            // Ticks at a standing time expire nothing while the hold is non-zero.
            if (roll < 8)
                w.command = CMD_TICK;
        end
        else if (roll < 18)
        begin
            t_base      = t_base + $urandom_range(0, span);
            w.command   = CMD_TICK;
            w.stamp     = t_base;
            w.banned    = 1'($urandom_range(0, 1));
            w.broadcast = 1'($urandom_range(0, 1));
        end
        else if (roll < 26)
        begin
            w.broadcast = 1'b1;
            w.banned    = 1'($urandom_range(0, 1));
        end
        else
        begin
            if ($urandom_range(0, 99) < 65)
                w.source = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            w.banned = ($urandom_range(0, 4) == 0);
            // Now and then a query carries a wild time, out of step with the rest.
            w.stamp  = ($urandom_range(0, 24) == 0) ? TIME_W'($urandom())
                                                     : t_base + $urandom_range(0, 2);
        end
        return w;
    endfunction

    // Gaps between words: mostly none or short, a few long.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 80);
    endfunction

    // Request driver. A word stays on the bus until it is taken; the prediction is made
    // at the edge that takes it, so expectations queue up in acceptance order.
    always @(posedge clk)
    begin : drive_requests
        logic accepted;
        logic offer;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            accepted = req_ch.valid && req_ch.ready;
            offer    = req_ch.valid;
            if (accepted)
            begin
                verdicts_due.push_back(judge_word(pending[0]));
                pending.pop_front();
                send_gap = tx_eager ? 0 : pick_gap();
                offer    = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() > 0)
                begin
                    offer                 = 1'b1;
                    req_ch.command        <= pending[0].command;
                    req_ch.now            <= pending[0].stamp;
                    req_ch.source_address <= pending[0].source;
                    req_ch.is_banned      <= pending[0].banned;
                    req_ch.is_broadcast   <= pending[0].broadcast;
                end
            end
            req_ch.valid <= offer;
        end
    end

    // Long receiver hold-off. Started while plenty of words are still waiting, so the
    // output register fills, the unit stops taking words and the sender sits stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
            holds_done   <= 0;
        end
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (holds_done < 2 && words_out >= 150 * (holds_done + 1) && pending.size() > 20)
        begin
            rx_hold_left <= HOLD_OFF_CYCLES;
            holds_done   <= holds_done + 1;
        end
    end

    // Verdict checker and receiver. Every word taken is compared with the oldest
    // prediction, all three fields at once; values print as verdict/overflow/expired.
    always @(posedge clk)
    begin : check_verdicts
        verdict_word_t due;
        logic          ready_next;
        int unsigned   roll;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                words_out++;
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: expected none, got %0d/%0b/%0d",
                             $time, rsp_ch.verdict, rsp_ch.overflow, rsp_ch.expired_count);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (rsp_ch.verdict !== due.verdict || rsp_ch.overflow !== due.overflow ||
                        rsp_ch.expired_count !== due.expired)
                    begin
                        errors++;
                        $display("%0t: word %0d: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                                 $time, words_out, due.verdict, due.overflow, due.expired,
                                 rsp_ch.verdict, rsp_ch.overflow, rsp_ch.expired_count);
                    end
                end
            end
            ready_next = 1'b1;
            if (rx_hold_left > 0)
                ready_next = 1'b0;
            else if (rx_stall > 0)
            begin
                rx_stall--;
                ready_next = 1'b0;
            end
            else if (!rx_eager)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 95)
                begin
                    rx_stall   = $urandom_range(15, 60);
                    ready_next = 1'b0;
                end
                else if (roll >= 70)
                begin
                    rx_stall   = $urandom_range(0, 3);
                    ready_next = 1'b0;
                end
            end
            rsp_ch.ready <= ready_next;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Waits until every word has been taken and answered, then lets a full ring walk
    // pass so the unit is certainly idle.
    task automatic drain();
        while (pending.size() != 0 || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (2 * RING_DEPTH) @(negedge clk);
    endtask

    // Writes the hold time register; only called while the unit is idle.
    task automatic set_hold(input logic [HOLD_W-1:0] seconds);
        @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.hold_seconds <= seconds;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        hold_reg = seconds;
    endtask

    task automatic run_phase(input logic [HOLD_W-1:0] seconds, input traffic_t mode,
                             input logic [TIME_W-1:0] start_time, input logic eager_tx,
                             input logic eager_rx);
        set_hold(seconds);
        tx_eager = eager_tx;
        rx_eager = eager_rx;
        t_base   = start_time;
        @(negedge clk);
        repeat (WORDS_PER_PHASE) pending.push_back(random_word(mode));
        drain();
    endtask

    initial
    begin
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_TICK;
        req_ch.now            = '0;
        req_ch.source_address = '0;
        req_ch.is_banned      = 1'b0;
        req_ch.is_broadcast   = 1'b0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.hold_seconds   = '0;

        foreach (addr_pool[i])
            addr_pool[i] = $urandom();
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words at the reset hold of ten seconds, i.e. 350 ticks.
        // A tick on the empty ring, with junk in the fields that ticks ignore.
        queue_word(CMD_TICK,  32'd0,          32'hDEAD_BEEF, 1'b1, 1'b1);
        // Admission, then a repeat that is suppressed even though it is banned.
        queue_word(CMD_QUERY, 32'd0,          32'h0000_0000, 1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'd1,          32'h0000_0000, 1'b1, 1'b0);
        // Banned, then broadcasts that bypass the ban and leave the ring alone.
        queue_word(CMD_QUERY, 32'd2,          32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word(CMD_QUERY, 32'd3,          32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_word(CMD_QUERY, 32'd3,          32'hFFFF_FFFF, 1'b0, 1'b1);
        queue_word(CMD_QUERY, 32'd4,          32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'd100,        32'h0A00_0001, 1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'd101,        32'h0A00_0001, 1'b1, 1'b0);
        queue_word(CMD_QUERY, 32'd102,        32'h0A00_0002, 1'b0, 1'b1);
        queue_word(CMD_QUERY, 32'd103,        32'h0A00_0002, 1'b0, 1'b0);
        // Expiry edges: one tick short, exactly on time, then several at once.
        queue_word(CMD_TICK,  32'd349,        32'h0,         1'b0, 1'b0);
        queue_word(CMD_TICK,  32'd350,        32'h0,         1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'd351,        32'h0000_0000, 1'b0, 1'b0);
        queue_word(CMD_TICK,  32'd453,        32'h5555_5555, 1'b1, 1'b0);
        queue_word(CMD_TICK,  32'hFFFF_FFFF,  32'hAAAA_AAAA, 1'b0, 1'b1);
        // Expiry times that wrap past the top of the time range.
        queue_word(CMD_QUERY, 32'hFFFF_FF00,  32'h1234_5678, 1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'hFFFF_FFFF,  32'h8765_4321, 1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'hFFFF_FFFF,  32'h1234_5678, 1'b1, 1'b0);
        queue_word(CMD_TICK,  32'h0000_005D,  32'h0,         1'b0, 1'b0);
        queue_word(CMD_TICK,  32'h0000_005E,  32'h0,         1'b0, 1'b0);
        queue_word(CMD_TICK,  32'h8000_0000,  32'h0,         1'b0, 1'b0);
        queue_word(CMD_QUERY, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_word(CMD_TICK,  32'd0,          32'hFFFF_FFFF, 1'b1, 1'b1);
        drain();

        // Random phases across the hold range, both extremes included. The fill phases
        // push well past a full ring, so the overflow flag is raised at least once.
        run_phase(8'd0,   MIX_TRAFFIC, 32'd0,                1'b0, 1'b0);
        run_phase(8'd255, FILL_RING,   32'd5000,             1'b1, 1'b0);
        run_phase(8'd1,   MIX_TRAFFIC, TIME_W'($urandom()),  1'b0, 1'b1);
        run_phase(HOLD_W'($urandom_range(2, 254)), MIX_TRAFFIC, TIME_W'($urandom()),
                  1'b0, 1'b0);
        run_phase(8'd255, MIX_TRAFFIC, 32'hFFFF_F000,        1'b1, 1'b1);
        run_phase(HOLD_W'($urandom_range(1, 254)), FILL_RING, TIME_W'($urandom()),
                  1'b0, 1'b0);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
